>>> src/xeu_pkg.sv
// ----------------------------------------------------------------------------
// xeu_pkg
// Types and entity tables shared by the XML entity unescape block.
// ----------------------------------------------------------------------------
package xeu_pkg;

    localparam int NUM_ENT     = 5;
    localparam int MAX_ENT_LEN = 6;
    localparam int PEND_DEPTH  = 5;
    localparam int BURST_MAX   = PEND_DEPTH + 1;
    localparam int Q_DEPTH     = 4;
    localparam int Q_PTR_W     = $clog2(Q_DEPTH);

    localparam logic [7:0] AMP = 8'h26;

    // entity text, padded with zeros past its length
    localparam logic [0:NUM_ENT-1][0:MAX_ENT_LEN-1][7:0] ENT_TEXT = '{
        '{8'h26, 8'h6c, 8'h74, 8'h3b, 8'h00, 8'h00},  // &lt;
        '{8'h26, 8'h67, 8'h74, 8'h3b, 8'h00, 8'h00},  // &gt;
        '{8'h26, 8'h61, 8'h6d, 8'h70, 8'h3b, 8'h00},  // &amp;
        '{8'h26, 8'h61, 8'h70, 8'h6f, 8'h73, 8'h3b},  // &apos;
        '{8'h26, 8'h71, 8'h75, 8'h6f, 8'h74, 8'h3b}   // &quot;
    };
    localparam logic [0:NUM_ENT-1][2:0] ENT_LEN  = '{3'd4, 3'd4, 3'd5, 3'd6, 3'd6};
    localparam logic [0:NUM_ENT-1][7:0] ENT_CHAR = '{8'h3c, 8'h3e, 8'h26, 8'h27, 8'h22};

    typedef struct packed {
        logic [7:0] in_byte;
        logic       in_last;
    } t_in_beat;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       out_last;
    } t_out_beat;

    // all result beats caused by one input beat
    typedef struct packed {
        logic [0:BURST_MAX-1][7:0] bytes;
        logic [2:0]                count;
        logic                      last;
    } t_burst;

endpackage

>>> src/xml_entity_unescape_top.sv
// ----------------------------------------------------------------------------
// xml_entity_unescape_top
// Decodes the five predefined XML entities in a byte stream of one value.
// ----------------------------------------------------------------------------
// Latency: a result beat is offered the cycle after the input beat that
//   causes it, when the queue is empty.
// Throughput: one input beat per cycle; each beat yields 0 to 6 output beats,
//   one per cycle while the output is ready, set by the serializer walking a burst.
// The four-entry burst queue absorbs flush bursts; input stalls only when full.
// Reset: synchronous, active low; clears the pending count, queue and index.
// ----------------------------------------------------------------------------
module xml_entity_unescape_top (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // input channel
    input  logic               i_valid,
    output logic               o_ready,
    input  xeu_pkg::t_in_beat  i_beat,
    // output channel
    output logic               o_valid,
    input  logic               i_ready,
    output xeu_pkg::t_out_beat o_beat
);
    import xeu_pkg::*;

    logic   accept;
    logic   push;
    logic   pop;
    logic   q_full;
    logic   q_empty;
    t_burst burst;
    t_burst head;

    // Input is taken whenever the queue has room, even while output stalls.
    assign o_ready = !q_full;
    assign accept  = i_valid && o_ready;

    // Front: keeps the held entity prefix and turns each beat into a burst
    // (flushed bytes followed by the new byte, or one decoded character).
    xeu_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_beat   (i_beat),
        .o_push   (push),
        .o_burst  (burst)
    );

    // Queue of bursts; empty bursts are never written.
    xeu_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_burst  (burst),
        .i_pop    (pop),
        .o_full   (q_full),
        .o_empty  (q_empty),
        .o_head   (head)
    );

    // Back: emits the head burst beat by beat, flagging the last of a value.
    xeu_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_empty  (q_empty),
        .i_head   (head),
        .o_pop    (pop),
        .o_valid  (o_valid),
        .i_ready  (i_ready),
        .o_beat   (o_beat)
    );

endmodule

>>> src/xeu_front.sv
// ----------------------------------------------------------------------------
// xeu_front
// Entity matcher: holds the pending prefix and builds one burst per beat.
// ----------------------------------------------------------------------------
module xeu_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  xeu_pkg::t_in_beat i_beat,
    output logic              o_push,
    output xeu_pkg::t_burst   o_burst
);
    import xeu_pkg::*;

    logic [7:0] r_pend [PEND_DEPTH];
    logic [2:0] r_cnt;
    logic [2:0] n_cnt;

    logic       complete;
    logic       prefix;
    logic       extend;
    logic [7:0] done_char;
    logic [7:0] b;
    logic       last;
    logic [2:0] newlen;

    assign b      = i_beat.in_byte;
    assign last   = i_beat.in_last;
    assign newlen = r_cnt + 3'd1;

    always_comb begin
        logic ok;
        complete  = 1'b0;
        prefix    = 1'b0;
        done_char = ENT_CHAR[0];
        for (int e = 0; e < NUM_ENT; e++) begin
            ok = (newlen <= ENT_LEN[e]);
            for (int i = 0; i < PEND_DEPTH; i++) begin
                if ((3'(i) < r_cnt) && (r_pend[i] != ENT_TEXT[e][i])) begin
                    ok = 1'b0;
                end
            end
            if (ENT_TEXT[e][r_cnt] != b) begin
                ok = 1'b0;
            end
            if (ok && (newlen == ENT_LEN[e])) begin
                complete  = 1'b1;
                done_char = ENT_CHAR[e];
            end
            if (ok && (newlen < ENT_LEN[e])) begin
                prefix = 1'b1;
            end
        end
        extend = !complete && prefix && (r_cnt < 3'(PEND_DEPTH));
    end

    // burst: held bytes, then the new byte (or the decoded character)
    always_comb begin
        for (int i = 0; i < BURST_MAX; i++) begin
            if ((i < PEND_DEPTH) && (3'(i) < r_cnt)) begin
                o_burst.bytes[i] = r_pend[i < PEND_DEPTH ? i : 0];
            end else begin
                o_burst.bytes[i] = b;
            end
        end
        o_burst.last = last;
        if (complete) begin
            o_burst.bytes[0] = done_char;
            o_burst.count    = 3'd1;
            n_cnt            = 3'd0;
        end else if (extend) begin
            o_burst.count = last ? newlen : 3'd0;
            n_cnt         = last ? 3'd0 : newlen;
        end else begin
            o_burst.count = ((b != AMP) || last) ? newlen : r_cnt;
            n_cnt         = ((b == AMP) && !last) ? 3'd1 : 3'd0;
        end
        o_push = i_accept && (o_burst.count != 3'd0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 3'd0;
        end else if (i_accept) begin
            r_cnt <= n_cnt;
        end
        if (i_accept) begin
            if (extend && !last) begin
                r_pend[r_cnt] <= b;
            end else if (!complete && (b == AMP) && !last) begin
                r_pend[0] <= AMP;
            end
        end
    end

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= 3'(PEND_DEPTH))
        else $error("pending count out of range");

    a_pend_amp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt != 3'd0) |-> (r_pend[0] == AMP))
        else $error("held prefix does not start with ampersand");

endmodule

>>> src/xeu_queue.sv
// ----------------------------------------------------------------------------
// xeu_queue
// Short burst queue between the matcher and the output serializer.
// ----------------------------------------------------------------------------
module xeu_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  xeu_pkg::t_burst i_burst,
    input  logic            i_pop,
    output logic            o_full,
    output logic            o_empty,
    output xeu_pkg::t_burst o_head
);
    import xeu_pkg::*;

    t_burst               r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0]   r_wr;
    logic [Q_PTR_W-1:0]   r_rd;
    logic [Q_PTR_W:0]     r_count;

    assign o_full  = (r_count == (Q_PTR_W+1)'(Q_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_head  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + Q_PTR_W'(1);
            end
            if (i_pop) begin
                r_rd <= r_rd + Q_PTR_W'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + (Q_PTR_W+1)'(1);
            end else if (!i_push && i_pop) begin
                r_count <= r_count - (Q_PTR_W+1)'(1);
            end
        end
        if (i_push) begin
            r_mem[r_wr] <= i_burst;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> (!o_full || i_pop))
        else $error("burst queue overflow");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_empty)
        else $error("burst queue underflow");

endmodule

>>> src/xeu_back.sv
// ----------------------------------------------------------------------------
// xeu_back
// Serializer: walks the head burst one output beat at a time.
// ----------------------------------------------------------------------------
module xeu_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_empty,
    input  xeu_pkg::t_burst    i_head,
    output logic               o_pop,
    output logic               o_valid,
    input  logic               i_ready,
    output xeu_pkg::t_out_beat o_beat
);
    import xeu_pkg::*;

    logic [2:0] r_idx;
    logic       at_end;

    assign o_valid         = !i_empty;
    assign at_end          = (r_idx == 3'(i_head.count - 3'd1));
    assign o_beat.out_byte = i_head.bytes[r_idx];
    assign o_beat.out_last = i_head.last && at_end;
    assign o_pop           = o_valid && i_ready && at_end;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= 3'd0;
        end else if (o_valid && i_ready) begin
            r_idx <= at_end ? 3'd0 : r_idx + 3'd1;
        end
    end

    a_idx_in_burst: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (r_idx < i_head.count))
        else $error("serializer index past end of burst");

endmodule
